[sv/rmm_pkg.sv]
// Shared types and constants for the RSSI min/max calibration sequencer.
package rmm_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned CHAN_W    = 6;
  localparam int unsigned SWEEP_W   = 8;
  localparam int unsigned S_DATA_W  = 40;
  localparam int unsigned M_DATA_W  = 80;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  // Item kinds carried in the input tuser field.
  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_BUTTON  = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_SWEEP_RUNS = 1'b0;
  localparam logic CFG_RX_B_EN    = 1'b1;

  typedef enum logic [2:0] {
    PH_WAIT_LOW  = 3'd0,
    PH_SCAN_LOW  = 3'd1,
    PH_WAIT_HIGH = 3'd2,
    PH_SCAN_HIGH = 3'd3,
    PH_DONE      = 3'd4
  } phase_t;

  // Architectural state of the sequencer.
  typedef struct packed {
    phase_t              phase;
    logic [CHAN_W-1:0]   channel;
    logic [SWEEP_W-1:0]  sweeps;
    logic [SAMPLE_W-1:0] low_a;
    logic [SAMPLE_W-1:0] high_a;
    logic [SAMPLE_W-1:0] low_b;
    logic [SAMPLE_W-1:0] high_b;
  } cal_state_t;

  // One input item after unpacking.
  typedef struct packed {
    logic [1:0]          mode;
    logic                rssi_stable;
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
    logic                is_mode_button;
    logic                short_press;
  } cal_item_t;

  // Per-item flags that go out with the result.
  typedef struct packed {
    logic refresh;
    logic save_request;
  } cal_flags_t;

  // Configuration values.
  typedef struct packed {
    logic [SWEEP_W-1:0] sweep_runs;
    logic               rx_b_en;
  } cal_cfg_t;

endpackage

[sv/rssi_min_max_calibration_sequencer_unit.sv]
// Top level of the RSSI min/max calibration sequencer with stream ports.
//
// Input items arrive on the s_* stream: s_tuser carries the item kind
// (sample tick, button event or restart), s_tdata the stability flag, both
// receiver samples and the button details. Every accepted item produces
// exactly one result item on the m_* stream with the phase, tuned channel,
// the four running extremes and the refresh and save flags.
// An item is captured in an input register, evaluated combinationally against
// the sequencer state and written to the output register together with the
// state update. A result passes from the input register to the output
// register, and one item per cycle is sustained while the receiver takes
// results; the combinational state update loop sets that rate.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more item, after which s_tready drops.
// Configuration goes through cfg_we/cfg_index/cfg_wdata and is applied at
// once; write it only while no item is in flight.
// Reset puts the sequencer in wait_low on channel 0 with the minima at
// 65535, the maxima at 0, sweep_runs at 10 and the second receiver enabled,
// and empties both registers.
module rssi_min_max_calibration_sequencer_unit
  import rmm_pkg::*;
#(
  parameter int unsigned CHANNEL_COUNT = 40
) (
  input  logic                clk,
  input  logic                rst,
  // Input stream.
  input  logic                s_tvalid,
  output logic                s_tready,
  // From bit 0: rssi_stable, sample_a[15:0], sample_b[15:0], is_mode_button,
  // short_press, zero fill.
  input  logic [S_DATA_W-1:0] s_tdata,
  // mode[1:0].
  input  logic [1:0]          s_tuser,
  // Result stream.
  output logic                m_tvalid,
  input  logic                m_tready,
  // From bit 0: phase[2:0], channel[5:0], min_a, max_a, min_b, max_b
  // (16 bits each), refresh, save_request, zero fill.
  output logic [M_DATA_W-1:0] m_tdata,
  // Configuration write port.
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [SWEEP_W-1:0]  cfg_wdata
);

  logic       in_valid;
  cal_item_t  in_item;
  logic       advance;
  cal_state_t state;
  cal_state_t state_next;
  cal_flags_t flags;
  cal_cfg_t   cfg;
  logic       out_valid;
  cal_state_t out_state;
  cal_flags_t out_flags;

  // An item moves to the output register when that register is empty or the receiver is taking its result.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_item.mode           <= s_tuser;
      in_item.rssi_stable    <= s_tdata[0];
      in_item.sample_a       <= s_tdata[16:1];
      in_item.sample_b       <= s_tdata[32:17];
      in_item.is_mode_button <= s_tdata[33];
      in_item.short_press    <= s_tdata[34];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sweep_runs <= SWEEP_W'(10);
      cfg.rx_b_en    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SWEEP_RUNS: cfg.sweep_runs <= cfg_wdata;
        CFG_RX_B_EN:    cfg.rx_b_en    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  rmm_update #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_update (
    .state      (state),
    .item       (in_item),
    .cfg        (cfg),
    .state_next (state_next),
    .flags      (flags)
  );

  // Sequencer state, updated as each item is evaluated.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase   <= PH_WAIT_LOW;
      state.channel <= '0;
      state.sweeps  <= '0;
      state.low_a   <= SAMPLE_MAX;
      state.high_a  <= '0;
      state.low_b   <= SAMPLE_MAX;
      state.high_b  <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_state <= state_next;
      out_flags <= flags;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_flags.save_request, out_flags.refresh,
                     out_state.high_b, out_state.low_b, out_state.high_a,
                     out_state.low_a, out_state.channel, out_state.phase};

  // A save is only ever reported together with the return to wait_low.
  a_save_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_flags.save_request |-> out_state.phase == PH_WAIT_LOW)
    else $error("save_request without return to wait_low");

  // The tuned channel stays inside the channel range.
  a_chan_range: assert property (@(posedge clk) disable iff (rst)
    32'(state.channel) < CHANNEL_COUNT)
    else $error("channel out of range");

  // State only moves when an item is evaluated.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("state changed without an item");

  // A held input item is not overwritten.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_item))
    else $error("input register overwritten while held");

  // Reset empties the output register.
  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

[sv/rmm_update.sv]
// Next-state and result flags for one item of the calibration sequencer.
module rmm_update
  import rmm_pkg::*;
#(
  parameter int unsigned CHANNEL_COUNT = 40
) (
  input  cal_state_t state,
  input  cal_item_t  item,
  input  cal_cfg_t   cfg,
  output cal_state_t state_next,
  output cal_flags_t flags
);

  localparam logic [CHAN_W:0] CHAN_LAST = (CHAN_W+1)'(CHANNEL_COUNT - 1);

  logic              chan_wrap;
  logic [SWEEP_W-1:0] sweeps_inc;

  assign chan_wrap  = ({1'b0, state.channel} == CHAN_LAST);
  assign sweeps_inc = state.sweeps + SWEEP_W'(1);

  always_comb begin
    state_next = state;
    flags      = '0;
    case (item.mode)
      MODE_TICK: begin
        if (item.rssi_stable) begin
          // Track extremes while a scan phase is active.
          if (state.phase == PH_SCAN_LOW) begin
            if (item.sample_a < state.low_a) state_next.low_a = item.sample_a;
            if (cfg.rx_b_en && item.sample_b < state.low_b) begin
              state_next.low_b = item.sample_b;
            end
          end else if (state.phase == PH_SCAN_HIGH) begin
            if (item.sample_a > state.high_a) state_next.high_a = item.sample_a;
            if (cfg.rx_b_en && item.sample_b > state.high_b) begin
              state_next.high_b = item.sample_b;
            end
          end
          // Step the channel; a wrap counts one full sweep.
          if (chan_wrap) begin
            state_next.channel = '0;
            state_next.sweeps  = sweeps_inc;
            if (sweeps_inc == cfg.sweep_runs) begin
              if (state.phase == PH_SCAN_LOW) begin
                state_next.phase = PH_WAIT_HIGH;
              end else if (state.phase == PH_SCAN_HIGH) begin
                state_next.phase = PH_DONE;
              end
              flags.refresh = 1'b1;
            end
          end else begin
            state_next.channel = state.channel + CHAN_W'(1);
          end
        end
      end
      MODE_BUTTON: begin
        if (item.is_mode_button && item.short_press) begin
          case (state.phase)
            PH_WAIT_LOW: begin
              state_next.phase   = PH_SCAN_LOW;
              state_next.sweeps  = '0;
              state_next.channel = '0;
              state_next.low_a   = SAMPLE_MAX;
              if (cfg.rx_b_en) state_next.low_b = SAMPLE_MAX;
            end
            PH_WAIT_HIGH: begin
              state_next.phase   = PH_SCAN_HIGH;
              state_next.sweeps  = '0;
              state_next.channel = '0;
              state_next.high_a  = '0;
              if (cfg.rx_b_en) state_next.high_b = '0;
            end
            PH_DONE: begin
              state_next.phase   = PH_WAIT_LOW;
              flags.save_request = 1'b1;
            end
            default: begin
            end
          endcase
          flags.refresh = 1'b1;
        end
      end
      MODE_RESTART: begin
        state_next.phase = PH_WAIT_LOW;
        flags.refresh    = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

[bench/tb_rssi_min_max_calibration_sequencer_unit.sv]
// Self-checking testbench for the RSSI min/max calibration sequencer stream unit.
module tb_rssi_min_max_calibration_sequencer_unit;
  import rmm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS    = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PLAN_LEN    = 6;

  // One result item as it sits on m_tdata, highest field first.
  typedef struct packed {
    logic                save_request;
    logic                refresh;
    logic [SAMPLE_W-1:0] max_b;
    logic [SAMPLE_W-1:0] min_b;
    logic [SAMPLE_W-1:0] max_a;
    logic [SAMPLE_W-1:0] min_a;
    logic [CHAN_W-1:0]   channel;
    phase_t              phase;
  } reading_t;

  // A row of the directed table; the reading is used only where it is typed in.
  typedef struct {
    cal_item_t item;
    bit        typed;
    reading_t  want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [1:0]          s_tuser = MODE_TICK;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                cfg_we = 1'b0;
  logic                cfg_index = CFG_SWEEP_RUNS;
  logic [SWEEP_W-1:0]  cfg_wdata = '0;

  // Mirror of the sequencer state and its configuration.
  cal_state_t cal_now;
  cal_cfg_t   cal_cfg;

  reading_t  awaited_readings[$];
  stim_row_t directed_rows[16];
  int        mismatches = 0;
  int        readings_seen = 0;
  int        cycles = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  // Random part: sweep setting, receiver B enable and item count per phase.
  int unsigned runs_plan[PLAN_LEN]  = '{1, 2, 1, 255, 0, 3};
  bit          rxb_plan[PLAN_LEN]   = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
  int          count_plan[PLAN_LEN] = '{200, 200, 200, 100, 100, 100};

  rssi_min_max_calibration_sequencer_unit #(
    .CHANNEL_COUNT(CHANNELS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic cal_item_t mk_item(logic [1:0] mode, logic stable,
                                        logic [SAMPLE_W-1:0] sa, logic [SAMPLE_W-1:0] sb,
                                        logic is_mode, logic is_short);
    cal_item_t it;
    it.mode           = mode;
    it.rssi_stable    = stable;
    it.sample_a       = sa;
    it.sample_b       = sb;
    it.is_mode_button = is_mode;
    it.short_press    = is_short;
    return it;
  endfunction

  function automatic reading_t mk_reading(phase_t ph, int ch, int mina, int maxa,
                                          int minb, int maxb, bit refresh, bit save);
    reading_t r;
    r.phase        = ph;
    r.channel      = CHAN_W'(ch);
    r.min_a        = SAMPLE_W'(mina);
    r.max_a        = SAMPLE_W'(maxa);
    r.min_b        = SAMPLE_W'(minb);
    r.max_b        = SAMPLE_W'(maxb);
    r.refresh      = refresh;
    r.save_request = save;
    return r;
  endfunction

  // Applies one item to the mirrored state and returns the reading it should produce.
  function automatic reading_t calibrate_item(cal_item_t it);
    reading_t r;
    logic     refresh;
    logic     save;
    refresh = 1'b0;
    save    = 1'b0;
    case (it.mode)
      MODE_TICK: begin
        if (it.rssi_stable) begin
          if (cal_now.phase == PH_SCAN_LOW) begin
            if (it.sample_a < cal_now.low_a) cal_now.low_a = it.sample_a;
            if (cal_cfg.rx_b_en && it.sample_b < cal_now.low_b) cal_now.low_b = it.sample_b;
          end else if (cal_now.phase == PH_SCAN_HIGH) begin
            if (it.sample_a > cal_now.high_a) cal_now.high_a = it.sample_a;
            if (cal_cfg.rx_b_en && it.sample_b > cal_now.high_b) cal_now.high_b = it.sample_b;
          end
          cal_now.channel = (cal_now.channel == CHANNELS - 1) ? '0 : cal_now.channel + 1'b1;
          // A wrap to channel zero completes one sweep.
          if (cal_now.channel == '0) begin
            cal_now.sweeps = cal_now.sweeps + 1'b1;
            if (cal_now.sweeps == cal_cfg.sweep_runs) begin
              if (cal_now.phase == PH_SCAN_LOW) cal_now.phase = PH_WAIT_HIGH;
              else if (cal_now.phase == PH_SCAN_HIGH) cal_now.phase = PH_DONE;
              refresh = 1'b1;
            end
          end
        end
      end
      MODE_BUTTON: begin
        if (it.is_mode_button && it.short_press) begin
          case (cal_now.phase)
            PH_WAIT_LOW: begin
              cal_now.phase   = PH_SCAN_LOW;
              cal_now.sweeps  = '0;
              cal_now.channel = '0;
              cal_now.low_a   = SAMPLE_MAX;
              if (cal_cfg.rx_b_en) cal_now.low_b = SAMPLE_MAX;
            end
            PH_WAIT_HIGH: begin
              cal_now.phase   = PH_SCAN_HIGH;
              cal_now.sweeps  = '0;
              cal_now.channel = '0;
              cal_now.high_a  = '0;
              if (cal_cfg.rx_b_en) cal_now.high_b = '0;
            end
            PH_DONE: begin
              save          = 1'b1;
              cal_now.phase = PH_WAIT_LOW;
            end
            default: ;
          endcase
          refresh = 1'b1;
        end
      end
      MODE_RESTART: begin
        cal_now.phase = PH_WAIT_LOW;
        refresh       = 1'b1;
      end
      default: ;
    endcase
    r.phase        = cal_now.phase;
    r.channel      = cal_now.channel;
    r.min_a        = cal_now.low_a;
    r.max_a        = cal_now.high_a;
    r.min_b        = cal_now.low_b;
    r.max_b        = cal_now.high_b;
    r.refresh      = refresh;
    r.save_request = save;
    return r;
  endfunction

  // Sample levels lean on the two extremes.
  function automatic logic [SAMPLE_W-1:0] pick_level();
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return '0;
    if (roll == 1) return SAMPLE_MAX;
    return SAMPLE_W'($urandom());
  endfunction

  // Mostly well-formed calibration traffic: presses in the waiting phases,
  // stable ticks while scanning, and a little noise of every kind.
  function automatic cal_item_t next_stimulus();
    cal_item_t   it;
    int unsigned roll;
    bit          scanning;
    it = mk_item(MODE_TICK, 1'b1, pick_level(), pick_level(),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    roll     = $urandom_range(0, 99);
    scanning = (cal_now.phase == PH_SCAN_LOW) || (cal_now.phase == PH_SCAN_HIGH);
    if (roll < 8) begin
      it.mode        = 2'($urandom_range(0, 3));
      it.rssi_stable = 1'($urandom_range(0, 1));
    end else if ((scanning && roll < 11) || (!scanning && roll < 70)) begin
      it.mode           = MODE_BUTTON;
      it.is_mode_button = 1'b1;
      it.short_press    = 1'b1;
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH reading %0d %s: got %0h, expected %0h", readings_seen, what, got, want);
    mismatches++;
  endtask

  // Offers one item, waits for the handshake and records its expected reading.
  task automatic send_item(cal_item_t it, bit typed, reading_t want);
    reading_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.mode;
    s_tdata  <= {5'b0, it.short_press, it.is_mode_button, it.sample_b, it.sample_a,
                 it.rssi_stable};
    do @(posedge clk); while (!s_tready);
    predicted = calibrate_item(it);
    awaited_readings.push_back(typed ? want : predicted);
  endtask

  // Holds the sender until every awaited reading has come back.
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (awaited_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [SWEEP_W-1:0] runs, logic rxb);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SWEEP_RUNS;
    cfg_wdata <= runs;
    @(posedge clk);
    cfg_index <= CFG_RX_B_EN;
    cfg_wdata <= SWEEP_W'(rxb);
    @(posedge clk);
    cfg_we <= 1'b0;
    cal_cfg.sweep_runs = runs;
    cal_cfg.rx_b_en    = rxb;
    @(posedge clk);
  endtask

  // Receiver side stalls at the current rate.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compares every accepted reading with the oldest expectation.
  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = reading_t'(m_tdata[$bits(reading_t)-1:0]);
      if (awaited_readings.size() == 0) begin
        report_mismatch("with no item pending, channel", int'(got.channel), 0);
      end else begin
        want = awaited_readings.pop_front();
        if (got.phase !== want.phase) begin
          report_mismatch("phase", int'(got.phase), int'(want.phase));
        end
        if (got.channel !== want.channel) begin
          report_mismatch("channel", int'(got.channel), int'(want.channel));
        end
        if (got.min_a !== want.min_a) begin
          report_mismatch("min_a", int'(got.min_a), int'(want.min_a));
        end
        if (got.max_a !== want.max_a) begin
          report_mismatch("max_a", int'(got.max_a), int'(want.max_a));
        end
        if (got.min_b !== want.min_b) begin
          report_mismatch("min_b", int'(got.min_b), int'(want.min_b));
        end
        if (got.max_b !== want.max_b) begin
          report_mismatch("max_b", int'(got.max_b), int'(want.max_b));
        end
        if (got.refresh !== want.refresh) begin
          report_mismatch("refresh", int'(got.refresh), int'(want.refresh));
        end
        if (got.save_request !== want.save_request) begin
          report_mismatch("save_request", int'(got.save_request), int'(want.save_request));
        end
      end
      readings_seen++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    reading_t blank;
    blank = '0;
    cal_now = '{phase: PH_WAIT_LOW, channel: '0, sweeps: '0, low_a: SAMPLE_MAX, high_a: '0,
                low_b: SAMPLE_MAX, high_b: '0};
    cal_cfg = '{sweep_runs: 8'd10, rx_b_en: 1'b1};

    // Directed cases from the reset state with ten sweeps and receiver B on.
    directed_rows = '{
      '{mk_item(MODE_TICK, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1), 1'b1,
        mk_reading(PH_WAIT_LOW, 0, 'hFFFF, 0, 'hFFFF, 0, 1'b0, 1'b0)},
      '{mk_item(2'd3, 1'b1, 16'h0000, 16'hFFFF, 1'b1, 1'b1), 1'b1,
        mk_reading(PH_WAIT_LOW, 0, 'hFFFF, 0, 'hFFFF, 0, 1'b0, 1'b0)},
      '{mk_item(MODE_BUTTON, 1'b1, 16'hFFFF, 16'h0000, 1'b0, 1'b1), 1'b1,
        mk_reading(PH_WAIT_LOW, 0, 'hFFFF, 0, 'hFFFF, 0, 1'b0, 1'b0)},
      '{mk_item(MODE_BUTTON, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b0), 1'b1,
        mk_reading(PH_WAIT_LOW, 0, 'hFFFF, 0, 'hFFFF, 0, 1'b0, 1'b0)},
      '{mk_item(MODE_RESTART, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0), 1'b1,
        mk_reading(PH_WAIT_LOW, 0, 'hFFFF, 0, 'hFFFF, 0, 1'b1, 1'b0)},
      '{mk_item(MODE_TICK, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0), 1'b1,
        mk_reading(PH_WAIT_LOW, 1, 'hFFFF, 0, 'hFFFF, 0, 1'b0, 1'b0)},
      '{mk_item(MODE_BUTTON, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1), 1'b1,
        mk_reading(PH_SCAN_LOW, 0, 'hFFFF, 0, 'hFFFF, 0, 1'b1, 1'b0)},
      '{mk_item(MODE_TICK, 1'b1, 16'h0000, 16'hFFFF, 1'b0, 1'b0), 1'b1,
        mk_reading(PH_SCAN_LOW, 1, 0, 0, 'hFFFF, 0, 1'b0, 1'b0)},
      '{mk_item(MODE_TICK, 1'b1, 16'hFFFF, 16'h0000, 1'b1, 1'b1), 1'b1,
        mk_reading(PH_SCAN_LOW, 2, 0, 0, 0, 0, 1'b0, 1'b0)},
      '{mk_item(MODE_TICK, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1), 1'b1,
        mk_reading(PH_SCAN_LOW, 2, 0, 0, 0, 0, 1'b0, 1'b0)},
      '{mk_item(MODE_BUTTON, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1), 1'b1,
        mk_reading(PH_SCAN_LOW, 2, 0, 0, 0, 0, 1'b1, 1'b0)},
      '{mk_item(MODE_RESTART, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1), 1'b1,
        mk_reading(PH_WAIT_LOW, 2, 0, 0, 0, 0, 1'b1, 1'b0)},
      '{mk_item(MODE_TICK, 1'b1, 16'h1234, 16'hABCD, 1'b1, 1'b0), 1'b0, blank},
      '{mk_item(MODE_BUTTON, 1'b0, 16'h5555, 16'hAAAA, 1'b1, 1'b1), 1'b1,
        mk_reading(PH_SCAN_LOW, 0, 'hFFFF, 0, 'hFFFF, 0, 1'b1, 1'b0)},
      '{mk_item(MODE_TICK, 1'b1, 16'h8000, 16'h7FFF, 1'b0, 1'b1), 1'b0, blank},
      '{mk_item(2'd3, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1), 1'b0, blank}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 17;
    recv_idle_pct = 84;
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random phases, each under its own configuration and idling pattern.
    for (int p = 0; p < PLAN_LEN; p++) begin
      quiesce();
      set_config(SWEEP_W'(runs_plan[p]), rxb_plan[p]);
      send_idle_pct = (p < 2) ? 17 : (p < 4) ? 84 : 0;
      recv_idle_pct = (p < 2) ? 84 : (p < 4) ? 17 : 0;
      for (int n = 0; n < count_plan[p]; n++) begin
        send_item(next_stimulus(), 1'b0, blank);
        if ($urandom_range(0, 99) == 0) quiesce();
      end
    end

    quiesce();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
sv/rmm_pkg.sv
sv/rmm_update.sv
sv/rssi_min_max_calibration_sequencer_unit.sv
bench/tb_rssi_min_max_calibration_sequencer_unit.sv
